FILE: rtl/core/quaternion_to_euler_drift_macros.svh
// Assertion macros for the quaternion to Euler block
`ifndef QUATERNION_TO_EULER_DRIFT_MACROS_SVH
`define QUATERNION_TO_EULER_DRIFT_MACROS_SVH
// Implication checked on every edge outside reset
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e check failed");
// Next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e check failed");
`endif

FILE: rtl/core/q2e_pkg.sv
// -----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, types and tables for the quaternion to Euler block.
// -----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
	localparam int CordicSteps   = 16;
	localparam int AngleFracBits = 13;
	localparam int StepW         = 5;
	localparam int OpW           = 36;  // CORDIC x/y width
	localparam int ProdW         = 32;  // product width
	localparam int RootW         = 18;  // floor sqrt of up to 2^33
	localparam int SqW           = 34;  // sqrt operand width
	localparam int SqIters       = 17;
	localparam int SqCntW        = 5;

	localparam logic [19:0] DriftReset = 20'd19599;
	localparam logic [31:0] TwoPiQ29   = 32'd3373259426;
	localparam logic signed [OpW-1:0] OneQ28 = OpW'(64'sd268435456);

	// datapath operations, one per sequencer step
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_PROD, OP_SUM, OP_SQRT_A, OP_SQRT_B, OP_CORDIC_INIT,
		OP_CORDIC_STEP, OP_CONV, OP_STORE
	} op_t;

	// which atan2 is under way
	typedef enum logic [1:0] {
		ANG_ROLL  = 2'd0,
		ANG_PITCH = 2'd1,
		ANG_YAW   = 2'd2
	} ang_t;

	typedef struct packed {
		op_t              op;
		ang_t             ang;
		logic [2:0]       sub;
		logic [StepW-1:0] step;
	} q2e_cmd_t;

	typedef struct packed {
		logic sqrt_done;
	} q2e_sts_t;

	function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
				5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/q2e_ctrl.sv
// -----------------------------------------------------------------------------
// q2e_ctrl
// Sequencer: issues datapath commands for one item at a time.
// -----------------------------------------------------------------------------
`default_nettype none
module q2e_ctrl import q2e_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire q2e_sts_t sts,
	output q2e_cmd_t      cmd
);
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PROD  = 9'b000000010,
		ST_SUM   = 9'b000000100,
		ST_SQA   = 9'b000001000,
		ST_SQB   = 9'b000010000,
		ST_CINIT = 9'b000100000,
		ST_CSTEP = 9'b001000000,
		ST_CONV  = 9'b010000000,
		ST_STORE = 9'b100000000
	} state_t;

	state_t state_q;
	logic [2:0] sub_q;
	logic [StepW-1:0] step_q;
	ang_t ang_q;
	logic out_full_q;
	logic accept;
	logic store_en;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_full_q;
	// output register is free, or its item leaves at this edge
	assign store_en  = (state_q == ST_STORE) && (!out_full_q || !out_stall);

	always_comb begin
		cmd.ang  = ang_q;
		cmd.sub  = sub_q;
		cmd.step = step_q;
		unique case (state_q)
			ST_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
			ST_PROD:  cmd.op = OP_PROD;
			ST_SUM:   cmd.op = OP_SUM;
			ST_SQA:   cmd.op = OP_SQRT_A;
			ST_SQB:   cmd.op = OP_SQRT_B;
			ST_CINIT: cmd.op = OP_CORDIC_INIT;
			ST_CSTEP: cmd.op = OP_CORDIC_STEP;
			ST_CONV:  cmd.op = OP_CONV;
			ST_STORE: cmd.op = store_en ? OP_STORE : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sub_q      <= '0;
			step_q     <= '0;
			ang_q      <= ANG_ROLL;
			out_full_q <= 1'b0;
		end else begin
			out_full_q <= store_en || (out_full_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROD;
						sub_q   <= '0;
					end
				end
				ST_PROD: begin
					// ten products go through the shared multiplier, two per term
					if (sub_q == 3'd4) begin
						state_q <= ST_SUM;
						sub_q   <= '0;
					end else
						sub_q <= sub_q + 3'd1;
				end
				ST_SUM: begin
					if (sub_q == 3'd4) begin
						state_q <= ST_SQA;
					end else
						sub_q <= sub_q + 3'd1;
				end
				ST_SQA: if (sts.sqrt_done) state_q <= ST_SQB;
				ST_SQB: begin
					if (sts.sqrt_done) begin
						state_q <= ST_CINIT;
						ang_q   <= ANG_ROLL;
					end
				end
				ST_CINIT: begin
					state_q <= ST_CSTEP;
					step_q  <= '0;
				end
				ST_CSTEP: begin
					if (step_q == StepW'(CordicSteps - 1)) begin
						priority if (ang_q == ANG_YAW) state_q <= ST_CONV;
						else begin
							state_q <= ST_CINIT;
							ang_q   <= (ang_q == ANG_ROLL) ? ANG_PITCH : ANG_YAW;
						end
						sub_q <= '0;
					end else
						step_q <= step_q + StepW'(1);
				end
				ST_CONV: begin
					if (sub_q == 3'd2) state_q <= ST_STORE;
					else sub_q <= sub_q + 3'd1;
				end
				ST_STORE: begin
					if (store_en)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/q2e_dp.sv
// -----------------------------------------------------------------------------
// q2e_dp
// Datapath: shared multiplier, bit-serial square root, shared CORDIC,
// angle conversion and drift accumulator.
// -----------------------------------------------------------------------------
`default_nettype none
module q2e_dp import q2e_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q2e_cmd_t           cmd,
	output q2e_sts_t                sts,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [19:0]        cfg_data,
	input  wire logic signed [15:0] qx,
	input  wire logic signed [15:0] qy,
	input  wire logic signed [15:0] qz,
	input  wire logic signed [15:0] qw,
	output logic signed [15:0]      roll,
	output logic signed [14:0]      pitch,
	output logic signed [15:0]      yaw,
	output logic                    pitch_clamped
);
	logic signed [15:0] x_q, y_q, z_q, w_q;
	logic signed [31:0] pa_q [5];   // products a of each term
	logic signed [31:0] pb_q [5];   // products b of each term
	logic signed [OpW-1:0] sinr_q, cosr_q, siny_q, cosy_q, s_q;
	logic clamp_q;
	logic [19:0] dps_q;
	logic [31:0] drift_q;
	logic [RootW-1:0] ra_q, rb_q;

	// operand select for the shared multiplier: a = ma0*ma1, b = mb0*mb1
	logic signed [15:0] ma0, ma1, mb0, mb1;
	always_comb begin
		unique case (cmd.sub)
			3'd0: begin ma0 = w_q; ma1 = x_q; mb0 = y_q; mb1 = z_q; end
			3'd1: begin ma0 = x_q; ma1 = x_q; mb0 = y_q; mb1 = y_q; end
			3'd2: begin ma0 = w_q; ma1 = z_q; mb0 = x_q; mb1 = y_q; end
			3'd3: begin ma0 = y_q; ma1 = y_q; mb0 = z_q; mb1 = z_q; end
			3'd4: begin ma0 = w_q; ma1 = y_q; mb0 = x_q; mb1 = z_q; end
			default: begin ma0 = '0; ma1 = '0; mb0 = '0; mb1 = '0; end
		endcase
	end

	// sums over registered products
	logic signed [OpW-1:0] tsum, tdif;
	always_comb begin
		tsum = OpW'(pa_q[cmd.sub]) + OpW'(pb_q[cmd.sub]);
		tdif = OpW'(pa_q[cmd.sub]) - OpW'(pb_q[cmd.sub]);
	end

	// bit-serial square root: two operand bits in, one root bit out per cycle
	logic [SqW-1:0] sq_rem_q;
	logic [RootW-1:0] sq_root_q;
	logic [SqCntW-1:0] sq_cnt_q;
	logic sq_busy_q;
	logic [SqW-1:0] sq_op;
	logic [RootW+1:0] sq_trial;
	logic [SqW+1:0] sq_rem_sh;
	logic signed [OpW-1:0] sq_base;
	function automatic logic [1:0] sq_op_bits(input logic [SqCntW-1:0] c);
		logic [SqCntW:0] idx;
		begin
			idx = {c, 1'b0};
			return {sq_op[idx+1], sq_op[idx]};
		end
	endfunction
	always_comb begin
		sq_base  = (cmd.op == OP_SQRT_A) ? (OneQ28 + s_q) : (OneQ28 - s_q);
		sq_op    = SqW'(sq_base) << 4;
		sq_rem_sh = {sq_rem_q, sq_op_bits(sq_cnt_q)};
		sq_trial = {sq_root_q, 2'b01};
	end
	assign sts.sqrt_done = sq_busy_q && (sq_cnt_q == '0);

	// CORDIC
	logic signed [OpW-1:0] cx_q, cy_q, dx, dy;
	logic [31:0] cz_q;
	logic signed [OpW-1:0] iy, ix;
	logic [31:0] iz;
	logic [31:0] ang_roll_q, ang_pitch_q, ang_yaw_q;
	always_comb begin
		unique case (cmd.ang)
			ANG_ROLL:  begin iy = sinr_q; ix = cosr_q; end
			ANG_PITCH: begin iy = OpW'(ra_q); ix = OpW'(rb_q); end
			ANG_YAW:   begin iy = siny_q; ix = cosy_q; end
			default:   begin iy = '0; ix = '0; end
		endcase
		iz = 32'h0;
		dx = cx_q >>> cmd.step;
		dy = cy_q >>> cmd.step;
	end

	// conversion to radians
	logic signed [31:0] cv_in;
	logic signed [32:0] pa_ext;
	logic signed [65:0] cv_prod;
	logic signed [65:0] cv_rnd;
	localparam int Sh = 61 - AngleFracBits;
	always_comb begin
		pa_ext = {ang_pitch_q[31], ang_pitch_q};
		if (pa_ext < 0) pa_ext = '0;
		if (pa_ext > 33'sd1073741824) pa_ext = 33'sd1073741824;
		unique case (cmd.sub)
			3'd0: cv_in = $signed(ang_roll_q);
			3'd1: cv_in = 32'(pa_ext * 2 - 33'sd1073741824);
			default: cv_in = $signed(ang_yaw_q - drift_q);
		endcase
		cv_prod = $signed({{34{cv_in[31]}}, cv_in}) * $signed({34'd0, TwoPiQ29});
		cv_rnd  = (cv_prod + (66'sd1 <<< (Sh - 1))) >>> Sh;
	end
	logic signed [15:0] roll_t_q, yaw_t_q;
	logic signed [14:0] pitch_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dps_q     <= DriftReset;
			drift_q   <= '0;
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) dps_q <= cfg_data;
			if (cmd.op == OP_STORE) drift_q <= drift_q + 32'(dps_q);
			if ((cmd.op == OP_SQRT_A || cmd.op == OP_SQRT_B)) begin
				if (!sq_busy_q) begin
					sq_busy_q <= 1'b1;
					sq_cnt_q  <= SqCntW'(SqIters - 1);
				end else if (sq_cnt_q == '0)
					sq_busy_q <= 1'b0;
				else
					sq_cnt_q <= sq_cnt_q - SqCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				x_q <= qx; y_q <= qy; z_q <= qz; w_q <= qw;
			end
			OP_PROD: begin
				pa_q[cmd.sub] <= ma0 * ma1;
				pb_q[cmd.sub] <= mb0 * mb1;
			end
			OP_SUM: begin
				unique case (cmd.sub)
					3'd0: sinr_q <= tsum <<< 1;
					3'd1: cosr_q <= OneQ28 - (tsum <<< 1);
					3'd2: siny_q <= tsum <<< 1;
					3'd3: cosy_q <= OneQ28 - (tsum <<< 1);
					default: begin
						if ((tdif <<< 1) > OneQ28) begin
							s_q <= OneQ28; clamp_q <= 1'b1;
						end else if ((tdif <<< 1) < -OneQ28) begin
							s_q <= -OneQ28; clamp_q <= 1'b1;
						end else begin
							s_q <= tdif <<< 1; clamp_q <= 1'b0;
						end
					end
				endcase
			end
			OP_SQRT_A, OP_SQRT_B: begin
				if (!sq_busy_q) begin
					sq_rem_q  <= '0;
					sq_root_q <= '0;
				end else begin
					if (sq_rem_sh >= (SqW+2)'(sq_trial)) begin
						sq_rem_q  <= SqW'(sq_rem_sh - (SqW+2)'(sq_trial));
						sq_root_q <= {sq_root_q[RootW-2:0], 1'b1};
					end else begin
						sq_rem_q  <= SqW'(sq_rem_sh);
						sq_root_q <= {sq_root_q[RootW-2:0], 1'b0};
					end
					if (sq_cnt_q == '0) begin
						if (sq_rem_sh >= (SqW+2)'(sq_trial)) begin
							if (cmd.op == OP_SQRT_A) ra_q <= {sq_root_q[RootW-2:0], 1'b1};
							else rb_q <= {sq_root_q[RootW-2:0], 1'b1};
						end else begin
							if (cmd.op == OP_SQRT_A) ra_q <= {sq_root_q[RootW-2:0], 1'b0};
							else rb_q <= {sq_root_q[RootW-2:0], 1'b0};
						end
					end
				end
			end
			OP_CORDIC_INIT: begin
				// negative x: rotate by pi first
				if (ix < 0) begin
					cx_q <= -ix; cy_q <= -iy; cz_q <= 32'h80000000;
				end else begin
					cx_q <= ix; cy_q <= iy; cz_q <= iz;
				end
			end
			OP_CORDIC_STEP: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + dy; cy_q <= cy_q - dx;
					cz_q <= cz_q + atan_entry(cmd.step);
				end else begin
					cx_q <= cx_q - dy; cy_q <= cy_q + dx;
					cz_q <= cz_q - atan_entry(cmd.step);
				end
				if (cmd.step == StepW'(CordicSteps - 1)) begin
					logic [31:0] zf;
					zf = (cy_q >= 0) ? cz_q + atan_entry(cmd.step)
						: cz_q - atan_entry(cmd.step);
					// both operands zero gives angle zero
					if (ix == 0 && iy == 0) zf = '0;
					unique case (cmd.ang)
						ANG_ROLL:  ang_roll_q  <= zf;
						ANG_PITCH: ang_pitch_q <= zf;
						default:   ang_yaw_q   <= zf;
					endcase
				end
			end
			OP_CONV: begin
				unique case (cmd.sub)
					3'd0: roll_t_q <= cv_rnd[15:0];
					3'd1: pitch_t_q <= cv_rnd[14:0];
					default: yaw_t_q <= cv_rnd[15:0];
				endcase
			end
			OP_STORE: begin
				roll <= roll_t_q; pitch <= pitch_t_q; yaw <= yaw_t_q;
				pitch_clamped <= clamp_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/quaternion_to_euler_drift.sv
// -----------------------------------------------------------------------------
// quaternion_to_euler_drift
// Quaternion to ZYX Euler angles with linear yaw drift correction.
// -----------------------------------------------------------------------------
// One item at a time. After the accepting edge: the product steps (two products
// each), the sum steps, two square roots (a setup and 17 bit-serial iterations
// each), three passes of the one shared CORDIC (a load and 16 steps each), the
// conversion steps and a store. The next item is taken once the result is
// stored. A stalled result holds only the store: the next item is taken and
// computed while the result waits in the output register.
`default_nettype none
`include "quaternion_to_euler_drift_macros.svh"
module quaternion_to_euler_drift import q2e_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [19:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] qx,
	input  wire logic signed [15:0] qy,
	input  wire logic signed [15:0] qz,
	input  wire logic signed [15:0] qw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      roll,
	output logic signed [14:0]      pitch,
	output logic signed [15:0]      yaw,
	output logic                    pitch_clamped
);
	q2e_cmd_t cmd;
	q2e_sts_t sts;

	assign cfg_ready = 1'b1;

	q2e_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	q2e_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_valid, .cfg_ready, .cfg_data,
		.qx, .qy, .qz, .qw, .roll, .pitch, .yaw, .pitch_clamped
	);

	`Q2E_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`Q2E_ASSERT_IMPL(a_hold_out, out_valid && out_stall && cmd.op == OP_STORE, 1'b0)
	`Q2E_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(roll))
endmodule
`default_nettype wire
